// ===== hdl/sfir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared types and constants of the sliding-window FIR unit.
// ----------------------------------------------------------------------------
package sfir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 34;
  localparam int OUT_W    = 35;
  localparam int MAX_TAPS = 8;
  localparam int FILL_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH  = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [OUT_W-1:0]    result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    tap_t                 data;
  } cfg_wr_t;

endpackage : sfir_pkg
`default_nettype wire

// ===== hdl/sfir_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_front
// Takes samples, keeps the sample history and fill count, and pushes each
// complete window into the queue.
// ----------------------------------------------------------------------------
module sfir_front #(
  parameter int NUM_TAPS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire sfir_pkg::sample_t                 in_sample,
  input  wire logic                              in_stream_start,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output sfir_pkg::sample_t [NUM_TAPS-1:0]       q_win
);
  import sfir_pkg::*;

  localparam int HIST_D = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;
  localparam logic [FILL_W-1:0] LAST = FILL_W'(NUM_TAPS - 1);

  sample_t [HIST_D-1:0] hist_r, hist_nxt, hist_shift;
  logic [FILL_W-1:0]    fill_r, fill_nxt, fill_eff;
  logic                 xfer, full_win;

  assign in_stall = q_full;
  assign xfer     = in_valid && !in_stall;
  assign fill_eff = in_stream_start ? '0 : fill_r;
  assign full_win = !(fill_eff < LAST);
  assign q_push   = xfer && full_win;

  // Window: history entries are the older positions, the current sample the newest.
  generate
    if (NUM_TAPS > 1) begin : g_multi
      assign q_win = {in_sample, hist_r};
    end else begin : g_single
      assign q_win = in_sample;
    end
    if (HIST_D > 1) begin : g_shift
      assign hist_shift = {in_sample, hist_r[HIST_D-1:1]};
    end else begin : g_noshift
      assign hist_shift = in_sample;
    end
  endgenerate

  always_comb begin
    hist_nxt = hist_r;
    fill_nxt = fill_r;
    if (xfer) begin
      if (!full_win) begin
        for (int k = 0; k < HIST_D; k++) begin
          if (FILL_W'(k) == fill_eff) hist_nxt[k] = in_sample;
        end
        fill_nxt = fill_eff + 1'b1;
      end else begin
        fill_nxt = fill_eff;
        if (NUM_TAPS > 1) hist_nxt = hist_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hist_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      hist_r <= hist_nxt;
    end
  end

endmodule : sfir_front
`default_nettype wire

// ===== hdl/sfir_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_queue
// Two-entry queue of sample windows between the front and the back end.
// ----------------------------------------------------------------------------
module sfir_queue #(
  parameter int NUM_TAPS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire sfir_pkg::sample_t [NUM_TAPS-1:0]  push_win,
  output logic                                   full,
  output logic                                   pop_valid,
  input  wire logic                              pop,
  output sfir_pkg::sample_t [NUM_TAPS-1:0]       pop_win
);
  import sfir_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  sample_t [NUM_TAPS-1:0] mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_win   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_win;
  end

endmodule : sfir_queue
`default_nettype wire

// ===== hdl/sfir_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_back
// Holds the taps and computes the dot product of each window in three
// stages: products, two partial sums, final sum in the output register.
// ----------------------------------------------------------------------------
module sfir_back #(
  parameter int NUM_TAPS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sfir_pkg::cfg_wr_t                 cfg,
  input  wire logic                              q_valid,
  output logic                                   q_pop,
  input  wire sfir_pkg::sample_t [NUM_TAPS-1:0]  q_win,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output sfir_pkg::result_t                      out_filtered
);
  import sfir_pkg::*;

  localparam int HALF = MAX_TAPS / 2;

  tap_t  [MAX_TAPS-1:0] taps_r;
  prod_t [MAX_TAPS-1:0] prod_r, prod_nxt;
  sum_t                 sum_lo_r, sum_hi_r, sum_lo_nxt, sum_hi_nxt;
  result_t              res_r, res_nxt;
  logic                 s1_v_r, s2_v_r, out_v_r;
  logic                 out_rdy, s2_rdy, s1_rdy;

  // Each stage moves when it is empty or the next stage takes its contents.
  assign out_rdy = !out_v_r || !out_stall;
  assign s2_rdy  = !s2_v_r || out_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign q_pop   = q_valid && s1_rdy;

  assign out_valid    = out_v_r;
  assign out_filtered = res_r;

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      prod_nxt[k] = '0;
    end
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod_nxt[k] = prod_t'(taps_r[k]) * prod_t'(q_win[k]);
    end
    sum_lo_nxt = '0;
    sum_hi_nxt = '0;
    for (int k = 0; k < HALF; k++) begin
      sum_lo_nxt = sum_lo_nxt + sum_t'(prod_r[k]);
      sum_hi_nxt = sum_hi_nxt + sum_t'(prod_r[k+HALF]);
    end
    res_nxt = result_t'(sum_lo_r) + result_t'(sum_hi_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg.we) taps_r[cfg.idx] <= cfg.data;
      if (s1_rdy)  s1_v_r  <= q_valid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (out_rdy) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) prod_r <= prod_nxt;
    if (s2_rdy && s1_v_r) begin
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
    if (out_rdy && s2_v_r) res_r <= res_nxt;
  end

endmodule : sfir_back
`default_nettype wire

// ===== hdl/sliding_window_fir_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_fir_unit
// Sliding-window FIR filter in correlation order with programmable Q1.15 taps.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | in_sample (s16), in_stream_start
//  out_     | output    | out_valid/out_stall| out_filtered (s35)
//  cfg_     | input     | cfg_we             | cfg_idx (tap 0..7), cfg_data (s16)
//
// One sample is taken every clock while in_stall is low. The window that a
// sample completes enters the queue at the edge that takes the sample, and its
// result passes the product, partial-sum and sum registers before it is
// offered. A stall on the output backs up the three back-end stages and the
// two-entry window queue before in_stall rises. Reset clears the taps, the
// history and the fill count; there is no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_fir_unit #(
  parameter int NUM_TAPS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire sfir_pkg::sample_t                     in_sample,
  input  wire logic                                  in_stream_start,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output sfir_pkg::result_t                          out_filtered,
  input  wire logic                                  cfg_we,
  input  wire logic [sfir_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire sfir_pkg::tap_t                        cfg_data
);
  import sfir_pkg::*;

  sample_t [NUM_TAPS-1:0] push_win, pop_win;
  logic                   q_full, q_push, q_valid, q_pop;
  cfg_wr_t                cfg;

  assign cfg = {cfg_we, cfg_idx, cfg_data};

  sfir_front #(.NUM_TAPS(NUM_TAPS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_stream_start (in_stream_start),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_win           (push_win)
  );

  sfir_queue #(.NUM_TAPS(NUM_TAPS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_win  (push_win),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_win   (pop_win)
  );

  sfir_back #(.NUM_TAPS(NUM_TAPS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_win        (pop_win),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered)
  );

endmodule : sliding_window_fir_unit
`default_nettype wire
